// ----- hw/rtl/pht_pkg.sv -----
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and constants for the pid hash table get-or-insert block.
// ----------------------------------------------------------------------------
package pht_pkg;

   localparam int TABLE_INDEX_BITS = 12;
   localparam int TABLE_SLOTS      = 1 << TABLE_INDEX_BITS;
   localparam int KEY_W            = 23;
   localparam int SLOT_W           = 12;
   localparam int ENTRY_W          = KEY_W + 1;

   typedef logic [TABLE_INDEX_BITS-1:0] index_type;
   typedef logic [KEY_W-1:0]            key_type;
   typedef logic [ENTRY_W-1:0]          entry_type;

   typedef struct packed {
      key_type key;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              was_found;
      logic              table_full;
   } rsp_payload_type;

   // memory port controls from the probe engine
   typedef struct packed {
      logic      wr_en;
      index_type wr_addr;
      entry_type wr_data;
      logic      rd_en;
      index_type rd_addr;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } state_type;

   function automatic logic [SLOT_W-1:0] to_slot_field(input index_type idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/pht_if.sv -----
// ----------------------------------------------------------------------------
// pht_if
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface pht_req_if;
   import pht_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pht_rsp_if;
   import pht_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pid_hash_table_get_or_insert.sv -----
// ----------------------------------------------------------------------------
// pid_hash_table_get_or_insert
// Get-or-insert of process ids in an open-addressed table with linear probing.
// ----------------------------------------------------------------------------
// one slot read per cycle from the table RAM; one item in flight at a time
// reset: a clearing pass writes all 4096 slots empty, with
// req ready low; the response register comes out of reset empty
module pid_hash_table_get_or_insert (
   input logic       clock,
   input logic       reset,
   pht_req_if.sink   req_ch,
   pht_rsp_if.source rsp_ch
);
   import pht_pkg::*;

   mem_req_type     mem_req;
   entry_type       rd_data;
   rsp_payload_type result;
   logic            done;
   logic            rsp_free;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   pht_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_key   (req_ch.data.key),
      .req_ready (req_ch.ready),
      .rsp_free  (rsp_free),
      .done      (done),
      .result    (result),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   pht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ----- hw/rtl/pht_ram.sv -----
// ----------------------------------------------------------------------------
// pht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pht_engine.sv -----
// ----------------------------------------------------------------------------
// pht_engine
// Probe sequencer: clears the table after reset, then walks slots one read
// per cycle until it finds the key, an empty slot, or has seen every slot.
// ----------------------------------------------------------------------------
module pht_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  pht_pkg::key_type         req_key,
   output logic                     req_ready,
   input  logic                     rsp_free,
   output logic                     done,
   output pht_pkg::rsp_payload_type result,
   output pht_pkg::mem_req_type     mem_req,
   input  pht_pkg::entry_type       rd_data
);
   import pht_pkg::*;

   state_type state_ff, state_in;
   index_type clr_ff, clr_in;
   index_type pos_ff, pos_in;
   index_type cnt_ff, cnt_in;
   key_type   key_ff, key_in;

   logic slot_occ;
   logic slot_hit;
   logic slot_empty;
   logic last_probe;

   assign slot_occ   = rd_data[ENTRY_W-1];
   assign slot_hit   = slot_occ && (rd_data[KEY_W-1:0] == key_ff);
   assign slot_empty = !slot_occ;
   assign last_probe = (cnt_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      key_ff <= key_in;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      result    = '0;
      mem_req   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            mem_req.wr_data = '0;
            clr_in          = clr_ff + index_type'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // first probe is key + 1, wrapped to the table
               key_in          = req_key;
               pos_in          = req_key[TABLE_INDEX_BITS-1:0] + index_type'(1);
               cnt_in          = '0;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pos_in;
               state_in        = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (slot_empty || slot_hit || last_probe) begin
               // hold the read data until the output register is free
               if (rsp_free) begin
                  done              = 1'b1;
                  result.slot       = (slot_empty || slot_hit) ? to_slot_field(pos_ff) : '0;
                  result.was_found  = slot_hit;
                  result.table_full = !slot_empty && !slot_hit;
                  if (slot_empty) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pos_ff;
                     mem_req.wr_data = {1'b1, key_ff};
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               pos_in          = pos_ff + index_type'(1);
               cnt_in          = cnt_ff + index_type'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pos_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/pht_checker.sv -----
// ----------------------------------------------------------------------------
// pht_checker
// Port-level checks on the get-or-insert block, bound to the top level.
// ----------------------------------------------------------------------------
module pht_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input pht_pkg::rsp_payload_type rsp_data
);
   import pht_pkg::*;

   // table is closed right after reset, as the clearing pass starts
   a_no_req_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // the input is closed right after an item is accepted
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while probing");

   a_full_result_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> (rsp_data.slot == '0 && !rsp_data.was_found))
      else $error("full result carries a slot or found flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind pid_hash_table_get_or_insert pht_checker u_pht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
